### rtl/rv32m_pkg.sv
// ---------------------------------------------------------------------------
// RV32M multiply/divide package
// Operation codes, widths and the record that travels down the cell row.
// ---------------------------------------------------------------------------
package rv32m_pkg;

  localparam int unsigned XLEN = 32;

  typedef enum logic [2:0] {
    FN_MUL    = 3'd0,
    FN_MULH   = 3'd1,
    FN_MULHSU = 3'd2,
    FN_MULHU  = 3'd3,
    FN_DIV    = 3'd4,
    FN_DIVU   = 3'd5,
    FN_REM    = 3'd6,
    FN_REMU   = 3'd7
  } func_t;

  // One in-flight operation. For multiplies, acc is the running product high
  // part and shreg holds the multiplier low bits/product low bits.
  // For divides, acc is the partial remainder and shreg the dividend/quotient.
  typedef struct packed {
    logic            valid;
    func_t           func;
    logic            is_div;
    logic            neg_res;   // negate the final result
    logic            special;   // divide by zero or overflow, result preset
    logic [XLEN-1:0] spec_val;
    logic [XLEN:0]   mcand;     // multiplicand (sign extended when signed) or divisor magnitude
    logic [XLEN:0]   acc;
    logic [XLEN-1:0] shreg;
  } slot_t;

endpackage

### rtl/rv32m_cell.sv
// ---------------------------------------------------------------------------
// RV32M cell
// One radix-2 step: shift-add multiply or restoring divide, then register.
// ---------------------------------------------------------------------------
module rv32m_cell import rv32m_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  last,
  input  slot_t din,
  output slot_t dout
);

  slot_t           nxt;
  logic [XLEN+1:0] sum;
  logic [XLEN:0]   rem_sh;
  logic [XLEN+1:0] diff;

  always_comb begin
    nxt = din;
    sum = '0;
    rem_sh = '0;
    diff = '0;
    if (!din.is_div) begin
      // Product bit: add multiplicand if the LSB is set. On the last step of a
      // signed multiplier the top bit has negative weight.
      if (din.shreg[0]) begin
        if (last && (din.func == FN_MULH)) begin
          sum = {din.acc[XLEN], din.acc} - {din.mcand[XLEN], din.mcand};
        end else begin
          sum = {din.acc[XLEN], din.acc} + {din.mcand[XLEN], din.mcand};
        end
      end else begin
        sum = {din.acc[XLEN], din.acc};
      end
      nxt.acc   = sum[XLEN+1:1];
      nxt.shreg = {sum[0], din.shreg[XLEN-1:1]};
    end else begin
      rem_sh = {din.acc[XLEN-1:0], din.shreg[XLEN-1]};
      diff   = {1'b0, rem_sh} - {1'b0, din.mcand};
      if (!diff[XLEN+1]) begin
        nxt.acc   = diff[XLEN:0];
        nxt.shreg = {din.shreg[XLEN-2:0], 1'b1};
      end else begin
        nxt.acc   = rem_sh;
        nxt.shreg = {din.shreg[XLEN-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.func     <= nxt.func;
      dout.is_div   <= nxt.is_div;
      dout.neg_res  <= nxt.neg_res;
      dout.special  <= nxt.special;
      dout.spec_val <= nxt.spec_val;
      dout.mcand    <= nxt.mcand;
      dout.acc      <= nxt.acc;
      dout.shreg    <= nxt.shreg;
    end
  end

endmodule

### rtl/rv32m_multiply_divide_unit_top.sv
// RV32M multiply/divide unit, top level.
// Pipeline: one setup stage, 32 step cells (the radix-2 cell row) and one
// result stage, all registered.
// Throughput: one beat per cycle; the whole row advances when the output
// register is empty or being drained.
// Reset: rst clears all valid flags synchronously; the data path is not reset.
module rv32m_multiply_divide_unit_top import rv32m_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // func[2:0], operand_a[34:3], operand_b[66:35], zeros
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // result[31:0]
);

  localparam int unsigned NCELL = XLEN;

  func_t           in_func;
  logic [XLEN-1:0] a, b, a_mag, b_mag;
  logic            a_neg, b_neg, adv;
  slot_t           setup;
  slot_t           row [NCELL+1];
  logic [XLEN-1:0] res_raw, res_fin;

  assign in_func = func_t'(s_axis_tdata[2:0]);
  assign a = s_axis_tdata[34:3];
  assign b = s_axis_tdata[66:35];
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  assign a_neg = a[XLEN-1] && (in_func == FN_MULH || in_func == FN_MULHSU ||
                               in_func == FN_DIV || in_func == FN_REM);
  assign b_neg = b[XLEN-1] && (in_func == FN_MULH || in_func == FN_DIV ||
                               in_func == FN_REM);
  assign a_mag = a[XLEN-1] ? (~a + 1'b1) : a;
  assign b_mag = b[XLEN-1] ? (~b + 1'b1) : b;

  always_comb begin
    setup = '0;
    setup.valid = s_axis_tvalid;
    setup.func  = in_func;
    setup.is_div = in_func[2];
    if (!in_func[2]) begin
      // Multiplicand a (sign extended when signed); multiplier b.
      setup.mcand = {a_neg, a};
      setup.shreg = b;
    end else begin
      setup.mcand = {1'b0, (in_func == FN_DIV || in_func == FN_REM) && b[XLEN-1] ? b_mag : b};
      setup.shreg = a_neg ? a_mag : a;
      if (in_func == FN_DIV) begin
        setup.neg_res = a_neg ^ b_neg;
      end else if (in_func == FN_REM) begin
        setup.neg_res = a_neg;
      end
      if (b == '0) begin
        setup.special  = 1'b1;
        setup.spec_val = in_func[1] ? a : '1;
      end else if ((in_func == FN_DIV || in_func == FN_REM) && a == {1'b1, {(XLEN-1){1'b0}}}
                   && b == '1) begin
        setup.special  = 1'b1;
        setup.spec_val = in_func[1] ? '0 : a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0].valid <= 1'b0;
    end else if (adv) begin
      row[0].valid <= setup.valid;
    end
    if (adv) begin
      row[0].func     <= setup.func;
      row[0].is_div   <= setup.is_div;
      row[0].neg_res  <= setup.neg_res;
      row[0].special  <= setup.special;
      row[0].spec_val <= setup.spec_val;
      row[0].mcand    <= setup.mcand;
      row[0].acc      <= setup.acc;
      row[0].shreg    <= setup.shreg;
    end
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rv32m_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .last(i == NCELL - 1),
      .din (row[i]),
      .dout(row[i+1])
    );
  end

  always_comb begin
    unique case (row[NCELL].func)
      FN_MUL:                       res_raw = row[NCELL].shreg;
      FN_MULH, FN_MULHSU, FN_MULHU: res_raw = row[NCELL].acc[XLEN-1:0];
      FN_DIV, FN_DIVU:              res_raw = row[NCELL].shreg;
      default:                      res_raw = row[NCELL].acc[XLEN-1:0];
    endcase
    if (row[NCELL].special) begin
      res_fin = row[NCELL].spec_val;
    end else if (row[NCELL].neg_res) begin
      res_fin = ~res_raw + 1'b1;
    end else begin
      res_fin = res_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= row[NCELL].valid;
    end
    if (adv) begin
      m_axis_tdata <= res_fin;
    end
  end

endmodule

### sim/rv32m_multiply_divide_unit_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RV32M multiply/divide unit testbench
// Drives operations through the input stream, computes each destination value
// independently and compares the results in order under random stalls.
// ---------------------------------------------------------------------------
module rv32m_multiply_divide_unit_top_test import rv32m_pkg::*;;

  localparam int RANDOM_OPS = 1650;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  class md_scoreboard;
    logic [31:0] pending_results[$];
    int errors = 0;

    function logic [31:0] compute_result(func_t fn, logic [31:0] a, logic [31:0] b);
      logic [63:0] prod;
      logic [31:0] mag_a, mag_b, q, r;
      mag_a = a[31] ? -a : a;
      mag_b = b[31] ? -b : b;
      case (fn)
        FN_MUL: begin
          prod = {32'd0, a} * {32'd0, b};
          return prod[31:0];
        end
        FN_MULH: begin
          prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          return prod[63:32];
        end
        FN_MULHSU: begin
          prod = {{32{a[31]}}, a} * {32'd0, b};
          return prod[63:32];
        end
        FN_MULHU: begin
          prod = {32'd0, a} * {32'd0, b};
          return prod[63:32];
        end
        FN_DIV: begin
          if (b == 0) return 32'hFFFF_FFFF;
          if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
          q = mag_a / mag_b;
          return (a[31] ^ b[31]) ? -q : q;
        end
        FN_DIVU: return (b == 0) ? 32'hFFFF_FFFF : a / b;
        FN_REM: begin
          if (b == 0) return a;
          if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'd0;
          r = mag_a % mag_b;
          return a[31] ? -r : r;
        end
        default: return (b == 0) ? a : a % b;
      endcase
    endfunction

    function void note_operation(func_t fn, logic [31:0] a, logic [31:0] b);
      pending_results.push_back(compute_result(fn, a, b));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want !== got) begin
          $display("%0t: result mismatch: expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  md_scoreboard board;

  rv32m_multiply_divide_unit_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: ready changes at the falling edge, beats are checked at the rising edge.
  always @(negedge clk) begin
    if (!rst) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  always @(posedge clk) begin
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[rv32m_multiply_divide_unit_top] ERROR");
      $finish;
    end
  end

  // Valid stays high from one beat to the next unless the sender idles.
  task automatic send_op(func_t fn, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, b, a, fn};
    do @(posedge clk); while (!s_axis_tready);
    board.note_operation(fn, a, b);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(16);
      4: return -$urandom_range(16);
      5: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++)
      send_op(func_t'($urandom_range(7)), pick_operand(), pick_operand());
  endtask

  initial begin
    logic [31:0] corners[6] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'd7};
    board = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every operation on extremes, plus division by zero and signed overflow.
    for (int f = 0; f < 8; f++) begin
      send_op(func_t'(f), corners[f % 6], corners[(f + 3) % 6]);
    end
    send_op(FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(FN_REM, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(FN_DIV, 32'hFFFF_FFF9, 32'd0);
    send_op(FN_DIVU, 32'h1234_5678, 32'd0);
    send_op(FN_REM, 32'hFFFF_FFF9, 32'd0);
    send_op(FN_REMU, 32'h1234_5678, 32'd0);
    send_op(FN_REM, 32'hFFFF_FFF9, 32'd2);
    send_op(FN_MULH, 32'h8000_0000, 32'h8000_0000);
    send_op(FN_MULHSU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FN_MULHU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    send_idle_pct = 33;
    recv_idle_pct = 54;
    run_random(550);
    s_axis_tvalid <= 1'b0;
    // Let the pipeline empty completely before the traffic continues.
    while (board.pending_results.size() != 0) @(negedge clk);
    send_idle_pct = 54;
    recv_idle_pct = 33;
    run_random(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(550);
    s_axis_tvalid <= 1'b0;

    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0)
      $display("[rv32m_multiply_divide_unit_top] OK");
    else
      $display("[rv32m_multiply_divide_unit_top] ERROR");
    $finish;
  end
endmodule
